>>> sv/mvsc_pkg.sv
package mvsc_pkg;

    localparam int TEMP_W      = 12;
    localparam int LIMIT_W     = 11;
    localparam int DEADBAND_W  = 8;
    localparam int LARGE_ERR_W = 10;
    localparam int TICKS_W     = 5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 16;

    localparam logic [TICKS_W-1:0] REST_TICKS  = 5'd30;
    localparam logic [TICKS_W-1:0] LONG_PULSE  = 5'd5;
    localparam logic [TICKS_W-1:0] OPEN_PULSE  = 5'd1;
    localparam logic [TICKS_W-1:0] CLOSE_PULSE = 5'd2;
    localparam logic [TICKS_W-1:0] FIRST_WAIT  = 5'd1;

    localparam logic signed [TEMP_W-1:0] HEAT_SETPOINT_RST     = 12'sd0;
    localparam logic [LIMIT_W-1:0]       BOILER_MAX_TEMP_RST   = 11'd800;
    localparam logic [LIMIT_W-1:0]       BOILER_SUPPLY_MIN_RST = 11'd450;
    localparam logic [LIMIT_W-1:0]       BOILER_RETURN_MIN_RST = 11'd300;
    localparam logic [DEADBAND_W-1:0]    DEADBAND_RST          = 8'd10;
    localparam logic [LARGE_ERR_W-1:0]   LARGE_ERROR_RST       = 10'd50;

    typedef enum logic [1:0] {
        VALVE_STOP  = 2'd0,
        VALVE_OPEN  = 2'd1,
        VALVE_CLOSE = 2'd2
    } valve_e_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEAT_SETPOINT     = 3'd0,
        REG_BOILER_MAX_TEMP   = 3'd1,
        REG_BOILER_SUPPLY_MIN = 3'd2,
        REG_BOILER_RETURN_MIN = 3'd3,
        REG_DEADBAND          = 3'd4,
        REG_LARGE_ERROR       = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] heat_setpoint;
        logic [LIMIT_W-1:0]       boiler_max_temp;
        logic [LIMIT_W-1:0]       boiler_supply_min;
        logic [LIMIT_W-1:0]       boiler_return_min;
        logic [DEADBAND_W-1:0]    deadband;
        logic [LARGE_ERR_W-1:0]   large_error;
    } cfg_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] supply_temp;
        logic                     supply_fault;
        logic signed [TEMP_W-1:0] outlet_temp;
        logic                     outlet_fault;
        logic signed [TEMP_W-1:0] return_temp;
        logic                     return_fault;
    } item_t;

    typedef struct packed {
        logic               boiler_drive;
        valve_e_t           valve_motor;
        logic [TICKS_W-1:0] ticks_left;
    } ctl_state_t;

    typedef struct packed {
        logic               decided;
        logic               overheat_alarm;
        logic               boiler_on;
        logic [1:0]         valve_cmd;
        logic [TICKS_W-1:0] wait_ticks;
    } result_t;

endpackage

>>> sv/mvsc_decide.sv
module mvsc_decide (
    input  mvsc_pkg::cfg_t       cfg,
    input  mvsc_pkg::item_t      item,
    input  mvsc_pkg::ctl_state_t state,
    output mvsc_pkg::ctl_state_t state_next,
    output mvsc_pkg::result_t    result
);
    import mvsc_pkg::*;

    localparam int CMP_W = TEMP_W + 2;

    logic signed [CMP_W-1:0] sup_x;
    logic signed [CMP_W-1:0] outl_x;
    logic signed [CMP_W-1:0] ret_x;
    logic signed [CMP_W-1:0] set_x;
    logic signed [CMP_W-1:0] max_x;
    logic signed [CMP_W-1:0] sup_min_x;
    logic signed [CMP_W-1:0] ret_min_x;
    logic signed [CMP_W-1:0] db_x;
    logic signed [CMP_W-1:0] big_x;
    logic signed [CMP_W-1:0] set_lo;
    logic signed [CMP_W-1:0] set_hi;
    logic signed [CMP_W-1:0] err_below;
    logic signed [CMP_W-1:0] err_above;
    logic                    any_fault;
    logic [TICKS_W-1:0]      wait_t;
    logic                    alarm;
    ctl_state_t              st;

    always_comb begin
        sup_x     = CMP_W'(item.supply_temp);
        outl_x    = CMP_W'(item.outlet_temp);
        ret_x     = CMP_W'(item.return_temp);
        set_x     = CMP_W'(cfg.heat_setpoint);
        max_x     = $signed({3'b000, cfg.boiler_max_temp});
        sup_min_x = $signed({3'b000, cfg.boiler_supply_min});
        ret_min_x = $signed({3'b000, cfg.boiler_return_min});
        db_x      = $signed({6'b000000, cfg.deadband});
        big_x     = $signed({4'b0000, cfg.large_error});
        set_lo    = set_x - db_x;
        set_hi    = set_x + db_x;
        err_below = set_x - outl_x;
        err_above = outl_x - set_x;
        any_fault = item.supply_fault | item.outlet_fault | item.return_fault;
    end

    always_comb begin
        st     = state;
        wait_t = FIRST_WAIT;
        alarm  = 1'b0;
        if (state.ticks_left != '0) begin
            st.ticks_left = state.ticks_left - 1'b1;
            result.decided        = 1'b0;
            result.overheat_alarm = 1'b0;
            result.wait_ticks     = '0;
        end else begin
            if (!item.supply_fault && sup_x > max_x) begin
                alarm  = 1'b1;
                wait_t = REST_TICKS;
            end
            if (set_x == '0) begin
                st.valve_motor = VALVE_CLOSE;
            end else if (set_x == max_x) begin
                st.boiler_drive = 1'b1;
                st.valve_motor  = VALVE_OPEN;
            end else if (set_x < 0 || any_fault) begin
                st.boiler_drive = 1'b0;
                st.valve_motor  = VALVE_CLOSE;
            end else begin
                st.boiler_drive = 1'b1;
                if (state.valve_motor != VALVE_STOP) begin
                    st.valve_motor = VALVE_STOP;
                    wait_t         = REST_TICKS;
                end else if (sup_x < sup_min_x || ret_x < ret_min_x) begin
                    st.valve_motor = VALVE_CLOSE;
                    wait_t         = REST_TICKS;
                end else if (outl_x <= set_lo) begin
                    st.valve_motor = VALVE_OPEN;
                    wait_t         = (err_below > big_x) ? LONG_PULSE : OPEN_PULSE;
                end else if (outl_x >= set_hi) begin
                    st.valve_motor = VALVE_CLOSE;
                    wait_t         = (err_above > big_x) ? LONG_PULSE : CLOSE_PULSE;
                end
            end
            st.ticks_left         = wait_t - 1'b1;
            result.decided        = 1'b1;
            result.overheat_alarm = alarm;
            result.wait_ticks     = wait_t;
        end
        result.boiler_on = st.boiler_drive;
        result.valve_cmd = st.valve_motor;
        state_next       = st;
    end

endmodule

>>> sv/mixing_valve_step_controller_core.sv
// channel   dir  handshake         payload
// s_        in   s_tvalid/tready   s_tdata: supply, outlet, return temps; s_tuser: faults
// m_        out  m_tvalid/tready   m_tdata: decided, alarm, boiler, valve, wait
// cfg_      in   cfg_valid/ready   cfg_index, cfg_data; always ready
//
// one word per cycle when m_ is not stalled; m_tvalid rises after the word passes
// the input register and then one pass of compare logic into the result register
// aresetn is synchronous: config registers return to defaults, state clears
// a stalled m_ side holds its word while one more s_ word waits in the input stage
module mixing_valve_step_controller_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // supply_temp[11:0], outlet_temp[23:12], return_temp[35:24], zero fill
    input  logic [mvsc_pkg::S_TDATA_W-1:0]   s_tdata,
    // supply_fault[0], outlet_fault[1], return_fault[2]
    input  logic [mvsc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // decided[0], overheat_alarm[1], boiler_on[2], valve_cmd[4:3], wait_ticks[9:5]
    output logic [mvsc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mvsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mvsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mvsc_pkg::*;

    cfg_t       cfg_reg;
    item_t      item_reg;
    logic       in_valid_reg;
    ctl_state_t state_reg;
    ctl_state_t state_next;
    result_t    res_reg;
    result_t    res_next;
    logic       out_valid_reg;
    logic       advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(M_TDATA_W - $bits(result_t))'(0),
                        res_reg.wait_ticks, res_reg.valve_cmd, res_reg.boiler_on,
                        res_reg.overheat_alarm, res_reg.decided};

    mvsc_decide u_decide (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.heat_setpoint     <= HEAT_SETPOINT_RST;
            cfg_reg.boiler_max_temp   <= BOILER_MAX_TEMP_RST;
            cfg_reg.boiler_supply_min <= BOILER_SUPPLY_MIN_RST;
            cfg_reg.boiler_return_min <= BOILER_RETURN_MIN_RST;
            cfg_reg.deadband          <= DEADBAND_RST;
            cfg_reg.large_error       <= LARGE_ERROR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_HEAT_SETPOINT:     cfg_reg.heat_setpoint     <= cfg_data;
                REG_BOILER_MAX_TEMP:   cfg_reg.boiler_max_temp   <= cfg_data[LIMIT_W-1:0];
                REG_BOILER_SUPPLY_MIN: cfg_reg.boiler_supply_min <= cfg_data[LIMIT_W-1:0];
                REG_BOILER_RETURN_MIN: cfg_reg.boiler_return_min <= cfg_data[LIMIT_W-1:0];
                REG_DEADBAND:          cfg_reg.deadband          <= cfg_data[DEADBAND_W-1:0];
                REG_LARGE_ERROR:       cfg_reg.large_error       <= cfg_data[LARGE_ERR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.supply_temp  <= s_tdata[TEMP_W-1:0];
            item_reg.outlet_temp  <= s_tdata[2*TEMP_W-1:TEMP_W];
            item_reg.return_temp  <= s_tdata[3*TEMP_W-1:2*TEMP_W];
            item_reg.supply_fault <= s_tuser[0];
            item_reg.outlet_fault <= s_tuser[1];
            item_reg.return_fault <= s_tuser[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.boiler_drive <= 1'b0;
            state_reg.valve_motor  <= VALVE_STOP;
            state_reg.ticks_left   <= '0;
            out_valid_reg          <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

endmodule

>>> sv/mvsc_checker.sv
module mvsc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mvsc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import mvsc_pkg::*;

    logic               decided;
    logic               alarm;
    logic [1:0]         valve;
    logic [TICKS_W-1:0] wait_t;

    assign decided = m_tdata[0];
    assign alarm   = m_tdata[1];
    assign valve   = m_tdata[4:3];
    assign wait_t  = m_tdata[9:5];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_wait_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !decided |-> wait_t == '0 && !alarm)
        else $error("waiting tick reports a wait or alarm");

    a_wait_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && decided |-> wait_t == REST_TICKS || wait_t == LONG_PULSE ||
                                wait_t == OPEN_PULSE || wait_t == CLOSE_PULSE)
        else $error("decision with illegal wait length");

    a_valve: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> valve != 2'd3)
        else $error("illegal valve command");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind mixing_valve_step_controller_core mvsc_checker u_mvsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/valve_tick_checker.sv
module valve_tick_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [mvsc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [mvsc_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [mvsc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [mvsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mvsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fails,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mvsc_pkg::*;

    cfg_t               regs;
    logic               boiler_drive;
    valve_e_t           valve_motor;
    logic [TICKS_W-1:0] ticks_left;
    result_t            expected_ticks[$];
    int                 words_seen;

    task automatic report(input string what, input int got, input int want);
        $display("word %0d: %s got %0d want %0d", words_seen, what, got, want);
        fails++;
    endtask

    // advances the controller state by one tick and returns the word it should produce
    function automatic result_t decide_tick(input item_t w);
        result_t            r;
        int                 sup;
        int                 outl;
        int                 ret;
        int                 sp;
        int                 top;
        int                 db;
        int                 big;
        logic [TICKS_W-1:0] hold;
        r = '0;
        if (ticks_left != 0) begin
            ticks_left = ticks_left - 1'b1;
            r.boiler_on = boiler_drive;
            r.valve_cmd = valve_motor;
            return r;
        end
        sup  = $signed(w.supply_temp);
        outl = $signed(w.outlet_temp);
        ret  = $signed(w.return_temp);
        sp   = $signed(regs.heat_setpoint);
        top  = int'(regs.boiler_max_temp);
        db   = int'(regs.deadband);
        big  = int'(regs.large_error);
        hold = FIRST_WAIT;
        if (!w.supply_fault && sup > top) begin
            r.overheat_alarm = 1'b1;
            hold = REST_TICKS;
        end
        if (sp == 0) begin
            valve_motor = VALVE_CLOSE;
        end else if (sp == top) begin
            boiler_drive = 1'b1;
            valve_motor = VALVE_OPEN;
        end else if (sp < 0 || w.supply_fault || w.outlet_fault || w.return_fault) begin
            boiler_drive = 1'b0;
            valve_motor = VALVE_CLOSE;
        end else begin
            boiler_drive = 1'b1;
            if (valve_motor != VALVE_STOP) begin
                valve_motor = VALVE_STOP;
                hold = REST_TICKS;
            end else if (sup < int'(regs.boiler_supply_min) ||
                         ret < int'(regs.boiler_return_min)) begin
                valve_motor = VALVE_CLOSE;
                hold = REST_TICKS;
            end else if (outl <= sp - db) begin
                valve_motor = VALVE_OPEN;
                hold = (sp - outl > big) ? LONG_PULSE : OPEN_PULSE;
            end else if (outl >= sp + db) begin
                valve_motor = VALVE_CLOSE;
                hold = (outl - sp > big) ? LONG_PULSE : CLOSE_PULSE;
            end
        end
        ticks_left = hold - 1'b1;
        r.decided = 1'b1;
        r.boiler_on = boiler_drive;
        r.valve_cmd = valve_motor;
        r.wait_ticks = hold;
        return r;
    endfunction

    always @(posedge aclk) begin
        item_t   w;
        result_t got;
        result_t want;
        if (!aresetn) begin
            regs.heat_setpoint     = HEAT_SETPOINT_RST;
            regs.boiler_max_temp   = BOILER_MAX_TEMP_RST;
            regs.boiler_supply_min = BOILER_SUPPLY_MIN_RST;
            regs.boiler_return_min = BOILER_RETURN_MIN_RST;
            regs.deadband          = DEADBAND_RST;
            regs.large_error       = LARGE_ERROR_RST;
            boiler_drive = 1'b0;
            valve_motor  = VALVE_STOP;
            ticks_left   = '0;
            expected_ticks.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HEAT_SETPOINT:     regs.heat_setpoint = cfg_data;
                    REG_BOILER_MAX_TEMP:   regs.boiler_max_temp = cfg_data[LIMIT_W-1:0];
                    REG_BOILER_SUPPLY_MIN: regs.boiler_supply_min = cfg_data[LIMIT_W-1:0];
                    REG_BOILER_RETURN_MIN: regs.boiler_return_min = cfg_data[LIMIT_W-1:0];
                    REG_DEADBAND:          regs.deadband = cfg_data[DEADBAND_W-1:0];
                    REG_LARGE_ERROR:       regs.large_error = cfg_data[LARGE_ERR_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.decided        = m_tdata[0];
                got.overheat_alarm = m_tdata[1];
                got.boiler_on      = m_tdata[2];
                got.valve_cmd      = m_tdata[4:3];
                got.wait_ticks     = m_tdata[9:5];
                if (expected_ticks.size() == 0) begin
                    report("word with nothing expected", m_tdata, 0);
                end else begin
                    want = expected_ticks.pop_front();
                    if (got.decided !== want.decided)
                        report("decided", got.decided, want.decided);
                    if (got.overheat_alarm !== want.overheat_alarm)
                        report("overheat_alarm", got.overheat_alarm, want.overheat_alarm);
                    if (got.boiler_on !== want.boiler_on)
                        report("boiler_on", got.boiler_on, want.boiler_on);
                    if (got.valve_cmd !== want.valve_cmd)
                        report("valve_cmd", got.valve_cmd, want.valve_cmd);
                    if (got.wait_ticks !== want.wait_ticks)
                        report("wait_ticks", got.wait_ticks, want.wait_ticks);
                end
                words_seen++;
            end
            if (s_tvalid && s_tready) begin
                w.supply_temp  = s_tdata[TEMP_W-1:0];
                w.outlet_temp  = s_tdata[2*TEMP_W-1:TEMP_W];
                w.return_temp  = s_tdata[3*TEMP_W-1:2*TEMP_W];
                w.supply_fault = s_tuser[0];
                w.outlet_fault = s_tuser[1];
                w.return_fault = s_tuser[2];
                expected_ticks.push_back(decide_tick(w));
            end
        end
        pending = expected_ticks.size();
    end

endmodule

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mvsc_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int QUIET_LIMIT  = 500;
    localparam int TICK_COUNT   = 1900;
    localparam int DRAIN_CYCLES = 4;
    localparam int CALM_FIRST   = 800;
    localparam int CALM_LAST    = 1100;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int fails;
    int pending;
    int ticks_sent;
    int quiet;
    int stall_left;
    bit calm = 1'b0;

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    mixing_valve_step_controller_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    valve_tick_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("mixing_valve_step_controller_core: mismatch");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // result side back-pressure in short bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(99) < 4) begin
            stall_left <= $urandom_range(3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic item_t mk_tick(input int sup, input bit s_bad, input int outl,
                                      input bit o_bad, input int ret, input bit r_bad);
        item_t w;
        w.supply_temp  = sup[TEMP_W-1:0];
        w.supply_fault = s_bad;
        w.outlet_temp  = outl[TEMP_W-1:0];
        w.outlet_fault = o_bad;
        w.return_temp  = ret[TEMP_W-1:0];
        w.return_fault = r_bad;
        return w;
    endfunction

    function automatic cfg_t pick_settings();
        cfg_t        c;
        int          mode;
        int          sp;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        mode = $urandom_range(99);
        if ($urandom_range(9) == 0)
            c.boiler_max_temp = $urandom_range(1) ? 11'h7FF : 11'd0;
        else
            c.boiler_max_temp = 11'($urandom_range(600, 1500));
        c.boiler_supply_min = 11'($urandom_range(600));
        c.boiler_return_min = 11'($urandom_range(450));
        c.deadband = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(40));
        c.large_error = ($urandom_range(9) == 0) ? 10'h3FF : 10'($urandom_range(200));
        if (mode < 8)
            sp = 0;
        else if (mode < 16)
            sp = int'(c.boiler_max_temp);
        else if (mode < 24)
            sp = -int'($urandom_range(1, 2048));
        else
            sp = $urandom_range(250, 750);
        c.heat_setpoint = sp[TEMP_W-1:0];
        if (mode >= 94)
            c = noise[$bits(cfg_t)-1:0];
        return c;
    endfunction

    function automatic item_t pick_tick(input cfg_t c);
        item_t       w;
        int          sp;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        if ($urandom_range(99) < 8) begin
            w = noise[$bits(item_t)-1:0];
            return w;
        end
        sp = $signed(c.heat_setpoint);
        if ($urandom_range(19) == 0)
            w.supply_temp = 12'(int'(c.boiler_max_temp) + int'($urandom_range(1, 100)));
        else
            w.supply_temp = 12'(int'(c.boiler_supply_min) + int'($urandom_range(560)) - 60);
        w.outlet_temp  = 12'(sp + int'($urandom_range(600)) - 300);
        w.return_temp  = 12'(int'(c.boiler_return_min) + int'($urandom_range(460)) - 60);
        w.supply_fault = ($urandom_range(99) < 3);
        w.outlet_fault = ($urandom_range(99) < 3);
        w.return_fault = ($urandom_range(99) < 3);
        return w;
    endfunction

    task automatic send_tick(input item_t w);
        if (!calm && $urandom_range(99) < 4) begin
            repeat ($urandom_range(1, 4)) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-3*TEMP_W){1'b0}}, w.return_temp, w.outlet_temp,
                     w.supply_temp};
        s_tuser  <= {w.return_fault, w.outlet_fault, w.supply_fault};
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // unused upper bits of the narrow registers carry random junk
    task automatic load_settings(input cfg_t c, input bit poke_spare);
        write_reg(REG_HEAT_SETPOINT, c.heat_setpoint);
        write_reg(REG_BOILER_MAX_TEMP, {1'($urandom), c.boiler_max_temp});
        write_reg(REG_BOILER_SUPPLY_MIN, {1'($urandom), c.boiler_supply_min});
        write_reg(REG_BOILER_RETURN_MIN, {1'($urandom), c.boiler_return_min});
        write_reg(REG_DEADBAND, {4'($urandom), c.deadband});
        write_reg(REG_LARGE_ERROR, {2'($urandom), c.large_error});
        if (poke_spare) begin
            write_reg(REG_SPARE_LO, 12'($urandom));
            write_reg(REG_SPARE_HI, 12'($urandom));
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        cfg_t c;
        int   phase_len;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        c.heat_setpoint     = HEAT_SETPOINT_RST;
        c.boiler_max_temp   = BOILER_MAX_TEMP_RST;
        c.boiler_supply_min = BOILER_SUPPLY_MIN_RST;
        c.boiler_return_min = BOILER_RETURN_MIN_RST;
        c.deadband          = DEADBAND_RST;
        c.large_error       = LARGE_ERROR_RST;

        // setpoint zero with field extremes, faulty supply above the limit
        send_tick(mk_tick(-2048, 1'b0, 2047, 1'b0, -2048, 1'b0));
        send_tick(mk_tick(2047, 1'b1, -2048, 1'b1, 2047, 1'b1));
        settle();
        // negative setpoint shuts down
        c.heat_setpoint = 12'h800;
        load_settings(c, 1'b0);
        send_tick(mk_tick(600, 1'b0, 500, 1'b0, 400, 1'b0));
        settle();
        // each sensor fault alone
        c.heat_setpoint = 12'sd500;
        load_settings(c, 1'b0);
        send_tick(mk_tick(600, 1'b0, 480, 1'b1, 400, 1'b0));
        send_tick(mk_tick(600, 1'b0, 480, 1'b0, 400, 1'b1));
        send_tick(mk_tick(600, 1'b1, 480, 1'b0, 400, 1'b0));
        settle();
        // setpoint at the limit forces full open; spare indexes ignored
        c.heat_setpoint   = 12'sd2047;
        c.boiler_max_temp = 11'h7FF;
        c.deadband        = 8'hFF;
        c.large_error     = 10'h3FF;
        load_settings(c, 1'b1);
        send_tick(mk_tick(1500, 1'b0, 1400, 1'b0, 1200, 1'b0));
        send_tick(mk_tick(-1000, 1'b0, -1000, 1'b0, -1000, 1'b0));
        settle();
        // valid supply over the limit raises the alarm and a long rest
        c.heat_setpoint     = 12'h800;
        c.boiler_max_temp   = 11'd0;
        c.boiler_supply_min = 11'h7FF;
        c.boiler_return_min = 11'd0;
        c.deadband          = 8'd0;
        c.large_error       = 10'd0;
        load_settings(c, 1'b0);
        send_tick(mk_tick(1, 1'b0, 0, 1'b0, 0, 1'b0));

        while (ticks_sent < TICK_COUNT) begin
            settle();
            c = pick_settings();
            load_settings(c, $urandom_range(3) == 0);
            calm = (ticks_sent >= CALM_FIRST && ticks_sent < CALM_LAST);
            phase_len = $urandom_range(30, 150);
            repeat (phase_len) send_tick(pick_tick(c));
        end
        settle();

        if (fails == 0 && pending == 0) begin
            $display("mixing_valve_step_controller_core: match");
        end else begin
            $display("mixing_valve_step_controller_core: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/mvsc_pkg.sv
sv/mvsc_decide.sv
sv/mixing_valve_step_controller_core.sv
sv/mvsc_checker.sv
sim/valve_tick_checker.sv
sim/tb_top.sv
